// ===== rtl/grc_pkg.sv =====
// Shared types and constants for the grid ray caster.
// Used by every module of the block except grc_ram; depends on nothing.
`default_nettype none

package grc_pkg;

  // Default grid bounds (top-level parameter defaults).
  localparam int GRC_MAX_ROWS = 256;
  localparam int GRC_MAX_COLS = 256;

  // Signed width of walk coordinates and error term; covers the center of a
  // 4096-wide grid plus the largest endpoint offset, and twice that offset.
  localparam int GRC_CW = 14;

  // Command queue depth between front and back.
  localparam int GRC_QUEUE_DEPTH = 2;

  // Input command codes.
  localparam logic GRC_CMD_WRITE = 1'b0;
  localparam logic GRC_CMD_CAST  = 1'b1;

  // Config register indexes.
  localparam logic [1:0] GRC_CFG_ROWS   = 2'd0;
  localparam logic [1:0] GRC_CFG_COLS   = 2'd1;
  localparam logic [1:0] GRC_CFG_THRESH = 2'd2;

  // Result kinds.
  localparam logic [1:0] GRC_KIND_OCC     = 2'd0;
  localparam logic [1:0] GRC_KIND_UNKNOWN = 2'd1;
  localparam logic [1:0] GRC_KIND_NONE    = 2'd2;

  localparam logic [7:0] GRC_CELL_UNKNOWN = 8'hFF;

  // Effective configuration seen by front and back.
  typedef struct packed {
    logic signed [GRC_CW-1:0] rows;
    logic signed [GRC_CW-1:0] cols;
    logic [6:0]               thresh;
  } grc_cfg_t;

  // One classified command. Cast fields are in walk space (steep swapped).
  typedef struct packed {
    logic                     is_cast;
    logic [7:0]               wr_row;
    logic [7:0]               wr_col;
    logic [7:0]               wr_value;
    logic                     steep;
    logic                     xs_neg;
    logic                     ys_neg;
    logic signed [GRC_CW-1:0] x;
    logic signed [GRC_CW-1:0] y;
    logic signed [GRC_CW-1:0] x_end;
    logic signed [GRC_CW-1:0] err;
    logic signed [GRC_CW-1:0] two_dy;
    logic signed [GRC_CW-1:0] two_dy_dx;
  } grc_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/grc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package use.
`default_nettype none

module grc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/grc_front.sv =====
// Front end: accepts input transactions, drops no-op ones, and turns casts
// into Bresenham walk setup. Depends on grc_pkg.
`default_nettype none

module grc_front
  import grc_pkg::*;
(
  input  grc_cfg_t          cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              command_i,
  input  logic [7:0]        cell_row_i,
  input  logic [7:0]        cell_col_i,
  input  logic signed [7:0] cell_value_i,
  input  logic signed [9:0] end_dx_i,
  input  logic signed [9:0] end_dy_i,
  input  logic              full_i,
  output logic              push_o,
  output grc_cmd_t          cmd_o
);

  logic signed [GRC_CW-1:0] ddx, ddy, adx, ady, x0, y0;
  logic signed [GRC_CW-1:0] sdx, sdy, sx0, sy0, sstep;
  logic                     steep, keep, wr_in_grid;

  assign ddx = GRC_CW'(end_dx_i);
  assign ddy = GRC_CW'(end_dy_i);
  assign adx = (ddx < 0) ? -ddx : ddx;
  assign ady = (ddy < 0) ? -ddy : ddy;
  assign x0  = cfg_i.cols >>> 1;
  assign y0  = cfg_i.rows >>> 1;

  assign steep = (ady >= adx);
  assign sx0   = steep ? y0 : x0;
  assign sy0   = steep ? x0 : y0;
  assign sstep = steep ? ddy : ddx;
  assign sdx   = steep ? ady : adx;
  assign sdy   = steep ? adx : ady;

  assign wr_in_grid = (GRC_CW'(cell_row_i) < cfg_i.rows) &&
                      (GRC_CW'(cell_col_i) < cfg_i.cols);

  // Zero offset casts and out-of-grid writes have no effect at all.
  always_comb begin
    if (command_i == GRC_CMD_CAST) begin
      keep = (end_dx_i != '0) || (end_dy_i != '0);
    end else begin
      keep = wr_in_grid;
    end
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i && keep;

  always_comb begin
    cmd_o           = '0;
    cmd_o.is_cast   = (command_i == GRC_CMD_CAST);
    cmd_o.wr_row    = cell_row_i;
    cmd_o.wr_col    = cell_col_i;
    cmd_o.wr_value  = cell_value_i;
    cmd_o.steep     = steep;
    cmd_o.xs_neg    = steep ? (ddy < 0) : (ddx < 0);
    cmd_o.ys_neg    = steep ? (ddx < 0) : (ddy < 0);
    cmd_o.x         = sx0;
    cmd_o.y         = sy0;
    cmd_o.x_end     = sx0 + sstep;
    cmd_o.two_dy    = sdy <<< 1;
    cmd_o.two_dy_dx = (sdy - sdx) <<< 1;
    cmd_o.err       = (sdy <<< 1) - sdx;
  end

endmodule

`default_nettype wire

// ===== rtl/grc_queue.sv =====
// Short command FIFO between front and back.
// Depends on grc_pkg for the command type and depth.
`default_nettype none

module grc_queue
  import grc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  grc_cmd_t data_i,
  input  logic     pop_i,
  output grc_cmd_t data_o,
  output logic     full_o,
  output logic     empty_o
);

  localparam int PW = (GRC_QUEUE_DEPTH > 1) ? $clog2(GRC_QUEUE_DEPTH) : 1;

  grc_cmd_t        slot_q [GRC_QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PW:0]     count_q;

  assign full_o  = (count_q == (PW+1)'(GRC_QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(GRC_QUEUE_DEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + 1'b1;
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/grc_back.sv =====
// Back end: executes cell writes and walks casts against the grid RAM,
// one cell read per cycle, and holds the result register.
// Depends on grc_pkg; drives the RAM ports of the top level.
`default_nettype none

module grc_back
  import grc_pkg::*;
#(
  parameter int MAX_ROWS = GRC_MAX_ROWS,
  parameter int MAX_COLS = GRC_MAX_COLS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  grc_cfg_t                               cfg_i,
  input  grc_cmd_t                               head_i,
  input  logic                                   empty_i,
  output logic                                   pop_o,
  output logic                                   we_o,
  output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]   waddr_o,
  output logic [7:0]                             wdata_o,
  output logic                                   re_o,
  output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]   raddr_o,
  input  logic [7:0]                             rdata_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [1:0]                             hit_kind_o,
  output logic [7:0]                             hit_row_o,
  output logic [7:0]                             hit_col_o
);

  localparam int AW  = $clog2(MAX_ROWS * MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CLW = $clog2(MAX_COLS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]               state_q, state_d;
  logic signed [GRC_CW-1:0] x_q, x_d, y_q, y_d, xend_q, xend_d, err_q, err_d;
  logic signed [GRC_CW-1:0] tdy_q, tdy_d, tdydx_q, tdydx_d;
  logic                     steep_q, steep_d, xs_neg_q, xs_neg_d, ys_neg_q, ys_neg_d;
  logic                     live_q, live_d, pend_q, pend_d;
  logic [RW-1:0]            pend_row_q, pend_row_d, last_row_q, last_row_d;
  logic [CLW-1:0]           pend_col_q, pend_col_d, last_col_q, last_col_d;
  logic [1:0]               kind_q, kind_d;

  logic signed [GRC_CW-1:0] cur_row, cur_col;
  logic                     pos_ok, is_occ, is_unk, out_load;

  assign cur_row = steep_q ? x_q : y_q;
  assign cur_col = steep_q ? y_q : x_q;
  assign pos_ok  = (x_q != xend_q) && (cur_col >= 0) && (cur_col < cfg_i.cols) &&
                   (cur_row >= 0) && (cur_row < cfg_i.rows);

  assign is_occ = $signed(rdata_i) > $signed({1'b0, cfg_i.thresh});
  assign is_unk = (rdata_i == GRC_CELL_UNKNOWN);

  assign waddr_o = AW'(head_i.wr_row) * AW'(MAX_COLS) + AW'(head_i.wr_col);
  assign wdata_o = head_i.wr_value;
  assign raddr_o = AW'(cur_row[RW-1:0]) * AW'(MAX_COLS) + AW'(cur_col[CLW-1:0]);

  assign out_load = (state_q == ST_FINISH) && (!out_valid_o || out_ready_i);

  always_comb begin
    state_d    = state_q;
    x_d        = x_q;
    y_d        = y_q;
    xend_d     = xend_q;
    err_d      = err_q;
    tdy_d      = tdy_q;
    tdydx_d    = tdydx_q;
    steep_d    = steep_q;
    xs_neg_d   = xs_neg_q;
    ys_neg_d   = ys_neg_q;
    live_d     = live_q;
    pend_d     = 1'b0;
    pend_row_d = pend_row_q;
    pend_col_d = pend_col_q;
    last_row_d = last_row_q;
    last_col_d = last_col_q;
    kind_d     = kind_q;
    pop_o      = 1'b0;
    we_o       = 1'b0;
    re_o       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (head_i.is_cast) begin
            x_d      = head_i.x;
            y_d      = head_i.y;
            xend_d   = head_i.x_end;
            err_d    = head_i.err;
            tdy_d    = head_i.two_dy;
            tdydx_d  = head_i.two_dy_dx;
            steep_d  = head_i.steep;
            xs_neg_d = head_i.xs_neg;
            ys_neg_d = head_i.ys_neg;
            live_d   = 1'b1;
            state_d  = ST_WALK;
          end else begin
            we_o = 1'b1;
          end
        end
      end

      ST_WALK: begin
        // Walker: issue the read for the current cell and step ahead.
        if (live_q) begin
          if (pos_ok) begin
            re_o       = 1'b1;
            pend_d     = 1'b1;
            pend_row_d = cur_row[RW-1:0];
            pend_col_d = cur_col[CLW-1:0];
            x_d        = xs_neg_q ? x_q - GRC_CW'(1) : x_q + GRC_CW'(1);
            if (err_q > 0) begin
              err_d = err_q + tdydx_q;
              y_d   = ys_neg_q ? y_q - GRC_CW'(1) : y_q + GRC_CW'(1);
            end else begin
              err_d = err_q + tdy_q;
            end
          end else begin
            live_d = 1'b0;
          end
        end
        // Checker: look at the cell read last cycle.
        if (pend_q) begin
          last_row_d = pend_row_q;
          last_col_d = pend_col_q;
          if (is_occ || is_unk) begin
            kind_d  = is_occ ? GRC_KIND_OCC : GRC_KIND_UNKNOWN;
            live_d  = 1'b0;
            pend_d  = 1'b0;
            state_d = ST_FINISH;
          end
        end else if (!live_q) begin
          kind_d  = GRC_KIND_NONE;
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    xend_q     <= xend_d;
    err_q      <= err_d;
    tdy_q      <= tdy_d;
    tdydx_q    <= tdydx_d;
    steep_q    <= steep_d;
    xs_neg_q   <= xs_neg_d;
    ys_neg_q   <= ys_neg_d;
    pend_row_q <= pend_row_d;
    pend_col_q <= pend_col_d;
    last_row_q <= last_row_d;
    last_col_q <= last_col_d;
    kind_q     <= kind_d;
    if (out_load) begin
      hit_kind_o <= kind_q;
      hit_row_o  <= 8'(last_row_q);
      hit_col_o  <= 8'(last_col_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      live_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      live_q  <= live_d;
      pend_q  <= pend_d;
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/grid_ray_cast_first_hit.sv =====
// Top level of the occupancy-grid ray caster: config registers, front end,
// command queue, back end and grid RAM. Depends on grc_pkg, grc_front, grc_queue, grc_back, grc_ram.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command per transaction.
//   A write (command_i = 0) stores cell_value_i at (cell_row_i, cell_col_i);
//   writes outside the configured grid are dropped. A cast (command_i = 1)
//   walks the Bresenham line from the grid center toward the center plus
//   (end_dx_i, end_dy_i) and returns one result transaction on the output
//   channel: the first occupied or unknown cell, else the last in-grid cell.
//   A cast with both offsets zero returns nothing.
//   Config channel (cfg_valid_i/cfg_ready_o) is always ready; index 0 sets
//   rows, 1 columns, 2 the occupancy threshold; other indexes are ignored.
//   Write it only while the block is idle.
// Timing:
//   A cast is dequeued, walked and then loaded into the output register; the
//   walk reads one cell per cycle from the single-read-port grid RAM, which
//   sets the rate. A write is performed in the cycle in which it is dequeued.
//   A two-entry queue lets the front keep accepting while the back is walking.
// Reset: clears control state and loads rows = cols = 256, threshold = 50.
//   Grid contents are undefined until written; no clearing pass is made.
// Stall: a result waits in the output register while out_ready_i is low; the
//   back end holds the next result until the register frees, and the input
//   side stalls once the queue fills.
`default_nettype none

module grid_ray_cast_first_hit
  import grc_pkg::*;
#(
  parameter int MAX_ROWS = GRC_MAX_ROWS,
  parameter int MAX_COLS = GRC_MAX_COLS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [8:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              command_i,
  input  logic [7:0]        cell_row_i,
  input  logic [7:0]        cell_col_i,
  input  logic signed [7:0] cell_value_i,
  input  logic signed [9:0] end_dx_i,
  input  logic signed [9:0] end_dy_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        hit_kind_o,
  output logic [7:0]        hit_row_o,
  output logic [7:0]        hit_col_o
);

  localparam int AW = $clog2(MAX_ROWS * MAX_COLS);

  // Config registers.
  logic [8:0] rows_q, cols_q;
  logic [6:0] thresh_q;
  grc_cfg_t   cfg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= 9'd256;
      cols_q   <= 9'd256;
      thresh_q <= 7'd50;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        GRC_CFG_ROWS:   rows_q   <= cfg_data_i;
        GRC_CFG_COLS:   cols_q   <= cfg_data_i;
        GRC_CFG_THRESH: thresh_q <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  // Effective grid size: zero acts as one, clamp to the RAM bounds.
  always_comb begin
    if (rows_q == '0) begin
      cfg.rows = GRC_CW'(1);
    end else if (GRC_CW'(rows_q) > GRC_CW'(MAX_ROWS)) begin
      cfg.rows = GRC_CW'(MAX_ROWS);
    end else begin
      cfg.rows = GRC_CW'(rows_q);
    end
    if (cols_q == '0) begin
      cfg.cols = GRC_CW'(1);
    end else if (GRC_CW'(cols_q) > GRC_CW'(MAX_COLS)) begin
      cfg.cols = GRC_CW'(MAX_COLS);
    end else begin
      cfg.cols = GRC_CW'(cols_q);
    end
    cfg.thresh = thresh_q;
  end

  grc_cmd_t front_cmd, head_cmd;
  logic     push, pop, full, empty;

  grc_front u_front (
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .cell_row_i   (cell_row_i),
    .cell_col_i   (cell_col_i),
    .cell_value_i (cell_value_i),
    .end_dx_i     (end_dx_i),
    .end_dy_i     (end_dy_i),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  grc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  grc_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .head_i      (head_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_kind_o  (hit_kind_o),
    .hit_row_o   (hit_row_o),
    .hit_col_o   (hit_col_o)
  );

  grc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROWS * MAX_COLS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/grc_checker.sv =====
// Port-level checks for the grid ray caster, bound to the top level.
// Depends on grc_pkg for result kind codes.
`default_nettype none

module grc_checker
  import grc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       command_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] hit_kind_o,
  input logic [7:0] hit_row_o,
  input logic [7:0] hit_col_o
);

  // Set once any cast transaction has been taken.
  logic cast_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cast_seen_q <= 1'b0;
    end else if (in_valid_i && in_ready_o && (command_i == GRC_CMD_CAST)) begin
      cast_seen_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(hit_kind_o) && $stable(hit_row_o) && $stable(hit_col_o))
    else $error("result payload changed while stalled");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_kind_o == GRC_KIND_OCC) || (hit_kind_o == GRC_KIND_UNKNOWN) ||
                    (hit_kind_o == GRC_KIND_NONE))
    else $error("illegal hit kind");

  a_no_result_without_cast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cast_seen_q)
    else $error("result without any cast");

endmodule

bind grid_ray_cast_first_hit grc_checker u_grc_checker (.*);

`default_nettype wire
